>>> hdl/nct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nct_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [2:0] CS_HALF   = 3'd3;
  localparam logic [2:0] CS_CLOSED = 3'd4;
  localparam logic [2:0] CS_LISTEN = 3'd0;
  localparam logic [2:0] CS_ESTAB  = 3'd2;

  localparam logic [2:0] FN_LOOKUP  = 3'd0;
  localparam logic [2:0] FN_CREATE  = 3'd1;
  localparam logic [2:0] FN_REVERSE = 3'd2;
  localparam logic [2:0] FN_UPDATE  = 3'd3;
  localparam logic [2:0] FN_SWEEP   = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [2:0] REG_PORT_MIN   = 3'd0;
  localparam logic [2:0] REG_PORT_MAX   = 3'd1;
  localparam logic [2:0] REG_LINGER     = 3'd2;
  localparam logic [2:0] REG_CLOSED_TMO = 3'd3;
  localparam logic [2:0] REG_UDP_IDLE   = 3'd4;
  localparam logic [2:0] REG_TCP_DEAD   = 3'd5;
  localparam logic [2:0] REG_TCP_IDLE   = 3'd6;

  localparam logic [15:0] PORT_MIN_RST   = 16'd10000;
  localparam logic [15:0] PORT_MAX_RST   = 16'd60000;
  localparam logic [31:0] LINGER_RST     = 32'd15000;
  localparam logic [31:0] CLOSED_TMO_RST = 32'd5000;
  localparam logic [31:0] UDP_IDLE_RST   = 32'd120000;
  localparam logic [31:0] TCP_DEAD_RST   = 32'd30000;
  localparam logic [31:0] TCP_IDLE_RST   = 32'd300000;

  localparam logic [6:0] COUNT_MAX = 7'd127;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  proto;
    logic [31:0] guest_addr;
    logic [15:0] src_port;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [15:0] proxy_port_in;
    logic [5:0]  slot;
    logic [2:0]  new_state;
    logic        released;
    logic        touch;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [15:0] proxy_port_out;
    logic [31:0] real_addr_out;
    logic [15:0] real_port_out;
    logic [2:0]  state_out;
    logic [6:0]  removed_count;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  proto;
    logic [15:0] src_port;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [15:0] nat_port;
    logic [2:0]  conn_state;
    logic        released;
    logic [31:0] last_active;
  } entry_t;

  typedef struct packed {
    logic [15:0] port_min;
    logic [15:0] port_max;
    logic [31:0] linger_ms;
    logic [31:0] closed_timeout_ms;
    logic [31:0] udp_idle_ms;
    logic [31:0] tcp_dead_ms;
    logic [31:0] tcp_idle_ms;
  } cfg_t;

  typedef struct packed {
    logic hit_fwd;
    logic hit_rev;
    logic free;
    logic in_use;
    logic drop;
  } eval_t;

  function automatic out_word_t miss_word();
    out_word_t w;
    w = '0;
    w.status = STATUS_MISS;
    return w;
  endfunction

  function automatic out_word_t answer(input logic [5:0] idx, input entry_t e);
    out_word_t w;
    w = '0;
    w.status         = STATUS_OK;
    w.slot_out       = idx;
    w.proxy_port_out = e.nat_port;
    w.real_addr_out  = e.dest_addr;
    w.real_port_out  = e.dest_port;
    w.state_out      = e.conn_state;
    return w;
  endfunction

endpackage
`default_nettype wire

>>> hdl/nct_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module nct_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire                 clk,
  input  wire                 rd_en,
  input  wire  [AW-1:0]       rd_addr,
  output nct_pkg::entry_t     rd_data,
  input  wire                 wr_en,
  input  wire  [AW-1:0]       wr_addr,
  input  nct_pkg::entry_t     wr_data
);
  import nct_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/nct_eval.sv
`timescale 1ns / 1ps
`default_nettype none
module nct_eval (
  input  nct_pkg::entry_t   ent,
  input  nct_pkg::in_word_t req,
  input  nct_pkg::cfg_t     cfg,
  input  wire  [15:0]       probe_port,
  output nct_pkg::eval_t    flags
);
  import nct_pkg::*;

  logic [31:0] age;
  logic [31:0] limit;
  logic        live;
  logic        lingered;
  logic        can_drop;

  always_comb begin
    age      = req.now_ms - ent.last_active;
    live     = ent.valid && (ent.conn_state != CS_CLOSED);
    lingered = (ent.proto == PROTO_TCP) && (ent.conn_state == CS_HALF) && ent.released &&
               (age > cfg.linger_ms);
    can_drop = 1'b1;
    if (ent.conn_state == CS_CLOSED) begin
      limit = cfg.closed_timeout_ms;
    end else if (ent.proto == PROTO_UDP) begin
      limit = cfg.udp_idle_ms;
    end else if (ent.proto == PROTO_TCP) begin
      limit = ent.released ? cfg.tcp_dead_ms : cfg.tcp_idle_ms;
    end else begin
      limit    = '0;
      can_drop = 1'b0;
    end
    flags.hit_fwd = live && !lingered && (ent.proto == req.proto) &&
                    (ent.src_port == req.src_port) && (ent.dest_addr == req.dest_addr) &&
                    (ent.dest_port == req.dest_port);
    flags.hit_rev = live && (ent.nat_port == req.proxy_port_in) && (ent.proto == req.proto);
    flags.free    = !ent.valid;
    flags.in_use  = live && (ent.nat_port == probe_port);
    flags.drop    = ent.valid && can_drop && (age > limit);
  end

endmodule
`default_nettype wire

>>> hdl/nat_connection_table.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  word        handshake
// in       input      in_data     in_valid / in_ready
// out      output     out_data    out_valid / out_ready
// cfg      input      cfg_wdata   cfg_we, no wait
// one entry is read per cycle from the table memory; lookup, reverse lookup, create slot
// search and sweep scan up to every table entry, update reads and, if valid, rewrites one slot
// create adds up to one table scan per proxy port probe, up to port_max - port_min probes
// after reset a clearing pass zeroes every entry before the first word is taken
// a new word is taken while a finished result waits at the output register
module nat_connection_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  nct_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output nct_pkg::out_word_t  out_data,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_addr,
  input  wire  [31:0]         cfg_wdata
);
  import nct_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] N_C    = CW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_C = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_ALLOC, S_PROBE, S_URD, S_UCK, S_WR, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  cfg_t        cfg_r;
  in_word_t    req_r, req_nxt;
  out_word_t   res_r, res_nxt;
  out_word_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        dv_r, dv_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [15:0] np_r, np_nxt;
  logic [15:0] port_r, port_nxt;
  logic [15:0] tries_r, tries_nxt;
  logic [6:0]  rm_r, rm_nxt;

  logic        rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t      rd_data, wr_data;
  eval_t       flags;

  logic        issue;
  logic        last;
  logic [16:0] np_inc;
  logic [15:0] np_taken;
  logic [15:0] try_lim;
  logic [6:0]  rm_inc;
  logic        slot_ok;
  entry_t      upd;

  nct_mem #(.DEPTH(TABLE_ENTRIES), .AW(IW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  nct_eval u_eval (
    .ent        (rd_data),
    .req        (req_r),
    .cfg        (cfg_r),
    .probe_port (port_r),
    .flags      (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.port_min          <= PORT_MIN_RST;
      cfg_r.port_max          <= PORT_MAX_RST;
      cfg_r.linger_ms         <= LINGER_RST;
      cfg_r.closed_timeout_ms <= CLOSED_TMO_RST;
      cfg_r.udp_idle_ms       <= UDP_IDLE_RST;
      cfg_r.tcp_dead_ms       <= TCP_DEAD_RST;
      cfg_r.tcp_idle_ms       <= TCP_IDLE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PORT_MIN:   cfg_r.port_min          <= cfg_wdata[15:0];
        REG_PORT_MAX:   cfg_r.port_max          <= cfg_wdata[15:0];
        REG_LINGER:     cfg_r.linger_ms         <= cfg_wdata;
        REG_CLOSED_TMO: cfg_r.closed_timeout_ms <= cfg_wdata;
        REG_UDP_IDLE:   cfg_r.udp_idle_ms       <= cfg_wdata;
        REG_TCP_DEAD:   cfg_r.tcp_dead_ms       <= cfg_wdata;
        REG_TCP_IDLE:   cfg_r.tcp_idle_ms       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cnt_nxt       = cnt_r;
    dv_nxt        = 1'b0;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    np_nxt        = np_r;
    port_nxt      = port_r;
    tries_nxt     = tries_r;
    rm_nxt        = rm_r;
    rd_en         = 1'b0;
    rd_addr       = cnt_r[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data;
    in_ready      = (state_r == S_IDLE);

    issue    = cnt_r < N_C;
    last     = dv_r && (idx_r == LAST_C);
    np_inc   = {1'b0, np_r} + 17'd1;
    np_taken = (np_inc > {1'b0, cfg_r.port_max}) ? cfg_r.port_min : np_inc[15:0];
    try_lim  = (cfg_r.port_max >= cfg_r.port_min) ? cfg_r.port_max - cfg_r.port_min : '0;
    rm_inc   = (rm_r == COUNT_MAX) ? rm_r : rm_r + 7'd1;
    slot_ok  = {26'd0, req_r.slot} < 32'(TABLE_ENTRIES);

    upd            = rd_data;
    upd.conn_state = (req_r.new_state > CS_CLOSED) ? CS_CLOSED : req_r.new_state;
    upd.released   = req_r.released;
    if (req_r.touch) begin
      upd.last_active = req_r.now_ms;
    end

    case (state_r)
      S_CLR: begin
        in_ready      = 1'b0;
        wr_en         = 1'b1;
        wr_addr       = cnt_r[IW-1:0];
        wr_data       = '0;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r[IW-1:0] == LAST_C) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          cnt_nxt = '0;
          rm_nxt  = '0;
          res_nxt = miss_word();
          case (in_data.func)
            FN_LOOKUP, FN_CREATE, FN_REVERSE, FN_SWEEP: state_nxt = S_SCAN;
            FN_UPDATE: state_nxt = S_URD;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        rd_en = issue;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
          dv_nxt  = 1'b1;
          idx_nxt = cnt_r[IW-1:0];
        end
        if (dv_r) begin
          case (req_r.func)
            FN_LOOKUP: begin
              if (flags.hit_fwd) begin
                res_nxt   = answer(6'(idx_r), rd_data);
                state_nxt = S_DONE;
                dv_nxt    = 1'b0;
              end else if (last) begin
                state_nxt = S_DONE;
              end
            end
            FN_REVERSE: begin
              if (flags.hit_rev) begin
                res_nxt   = answer(6'(idx_r), rd_data);
                state_nxt = S_DONE;
                dv_nxt    = 1'b0;
              end else if (last) begin
                state_nxt = S_DONE;
              end
            end
            FN_CREATE: begin
              if (flags.free) begin
                slot_nxt  = idx_r;
                tries_nxt = '0;
                state_nxt = S_ALLOC;
                dv_nxt    = 1'b0;
              end else if (last) begin
                res_nxt        = '0;
                res_nxt.status = STATUS_FULL;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              if (flags.drop) begin
                wr_en         = 1'b1;
                wr_data.valid = 1'b0;
                rm_nxt        = rm_inc;
              end
              if (last) begin
                res_nxt               = '0;
                res_nxt.status        = STATUS_OK;
                res_nxt.removed_count = flags.drop ? rm_inc : rm_r;
                state_nxt             = S_DONE;
              end
            end
          endcase
        end
      end
      S_ALLOC: begin
        port_nxt = np_r;
        np_nxt   = np_taken;
        cnt_nxt  = '0;
        if (tries_r < try_lim) begin
          tries_nxt = tries_r + 16'd1;
          state_nxt = S_PROBE;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_PROBE: begin
        rd_en = issue;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
          dv_nxt  = 1'b1;
          idx_nxt = cnt_r[IW-1:0];
        end
        if (dv_r && flags.in_use) begin
          state_nxt = S_ALLOC;
          dv_nxt    = 1'b0;
        end else if (last) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        wr_en               = 1'b1;
        wr_addr             = slot_r;
        wr_data.valid       = 1'b1;
        wr_data.proto       = req_r.proto;
        wr_data.src_port    = req_r.src_port;
        wr_data.dest_addr   = req_r.dest_addr;
        wr_data.dest_port   = req_r.dest_port;
        wr_data.nat_port    = port_r;
        wr_data.conn_state  = (req_r.proto == PROTO_TCP) ? CS_LISTEN : CS_ESTAB;
        wr_data.released    = 1'b0;
        wr_data.last_active = req_r.now_ms;
        res_nxt             = answer(6'(slot_r), wr_data);
        state_nxt           = S_DONE;
      end
      S_URD: begin
        rd_addr = IW'(req_r.slot);
        if (slot_ok) begin
          rd_en     = 1'b1;
          state_nxt = S_UCK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UCK: begin
        if (rd_data.valid) begin
          wr_en   = 1'b1;
          wr_addr = IW'(req_r.slot);
          wr_data = upd;
          res_nxt = answer(req_r.slot, upd);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      np_r        <= PORT_MIN_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      np_r        <= np_nxt;
    end
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    port_r  <= port_nxt;
    tries_r <= tries_nxt;
    rm_r    <= rm_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> hdl/nct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module nct_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_ready,
  input nct_pkg::out_word_t  out_data
);
  import nct_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |->
      out_data.slot_out == 6'd0 && out_data.proxy_port_out == 16'd0 &&
      out_data.removed_count == 7'd0)
    else $error("miss or full word carries data");

  a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.removed_count != 7'd0 |->
      out_data.status == STATUS_OK && out_data.slot_out == 6'd0 &&
      out_data.real_addr_out == 32'd0)
    else $error("sweep word carries entry data");

endmodule

bind nat_connection_table nct_checker u_nct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
